// ===== hdl/sfa_pkg.sv =====
// ----------------------------------------------------------------------------
// sfa_pkg
// Shared types and constants of the segment fit allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sfa_pkg;

    localparam int OWNER_W      = 16;
    localparam int SIZE_W       = 24;
    localparam int MAX_SEG_DEF  = 32;

    localparam logic [SIZE_W-1:0] TOTAL_RST  = 24'd1048576;
    localparam logic              POLICY_RST = 1'b1;
    localparam logic [SIZE_W-1:0] SIZE_MAX   = {SIZE_W{1'b1}};

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic POL_BEST  = 1'b0;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_MEM  = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NO_OWN  = 2'd3;

    localparam logic [0:0] REG_TOTAL  = 1'b0;
    localparam logic [0:0] REG_POLICY = 1'b1;

    typedef struct packed {
        logic [OWNER_W-1:0] owner;
        logic [SIZE_W-1:0]  size;
        logic               is_free;
    } t_seg;

    typedef struct packed {
        logic              load;
        logic [SIZE_W-1:0] total;
        logic              policy;
    } t_cfg;

endpackage

`default_nettype wire

// ===== hdl/sfa_if.sv =====
// ----------------------------------------------------------------------------
// sfa_if
// Request and response channels of the segment fit allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sfa_req_if
    import sfa_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [OWNER_W-1:0] owner_id;
    logic [SIZE_W-1:0]  request_size;

    modport source (output valid, req_type, owner_id, request_size, input ready);
    modport sink   (input valid, req_type, owner_id, request_size, output ready);
endinterface

interface sfa_rsp_if
    import sfa_pkg::*;
#(
    parameter int CNT_W = 6
) ();
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [SIZE_W-1:0] available_memory;
    logic [CNT_W-1:0]  segment_count;

    modport source (output valid, status, available_memory, segment_count, input ready);
    modport sink   (input valid, status, available_memory, segment_count, output ready);
endinterface

`default_nettype wire

// ===== hdl/sfa_cell.sv =====
// ----------------------------------------------------------------------------
// sfa_cell
// One table slot; takes the entry at its input on every shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfa_cell
    import sfa_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_shift,
    input  wire t_seg i_d,
    output t_seg      o_q
);

    t_seg r_seg;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_seg <= i_d;
        end
    end

    assign o_q = r_seg;

endmodule

`default_nettype wire

// ===== hdl/sfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfa_ctrl
// Sequencer: scans the rotating table, plans the edit, rewrites the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfa_ctrl
    import sfa_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEG_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    sfa_req_if.sink   i_req,
    sfa_rsp_if.source o_rsp,
    input  wire t_seg i_head,
    input  wire t_seg i_n1,
    input  wire t_seg i_n2,
    output logic      o_shift,
    output t_seg      o_tail
);

    localparam int CW = $clog2(MAX_SEGMENTS + 2);
    localparam int UW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CW-1:0] K_LAST = CW'(MAX_SEGMENTS - 1);
    localparam logic [CW-1:0] K_ALL  = CW'(MAX_SEGMENTS);
    localparam logic [UW-1:0] U_MAX  = UW'(MAX_SEGMENTS);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_PLAN, S_EDIT, S_RESP} t_state;
    typedef enum logic [1:0] {SRC_CUR, SRC_N1, SRC_N2, SRC_PREV} t_src;

    t_state             r_state;
    logic [CW-1:0]      r_k;
    logic               r_op;
    logic [OWNER_W-1:0] r_owner;
    logic [SIZE_W-1:0]  r_size;
    logic               r_found;
    logic [CW-1:0]      r_pick;
    logic [SIZE_W-1:0]  r_pick_size;
    logic               r_first_free;
    logic               r_lf;
    logic               r_rf;
    logic [SIZE_W-1:0]  r_lsize;
    logic [SIZE_W-1:0]  r_rsize;
    t_seg               r_prev;
    logic               r_ovr_en;
    logic [CW-1:0]      r_ovr_pos;
    t_seg               r_ovr;
    logic               r_ins_en;
    logic [CW-1:0]      r_ins_pos;
    logic [CW-1:0]      r_brk;
    t_src               r_lo;
    t_src               r_hi;
    logic [SIZE_W-1:0]  r_free_total;
    logic [UW-1:0]      r_used;
    logic [SIZE_W-1:0]  r_new_total;
    logic [UW-1:0]      r_new_used;
    logic [1:0]         r_status;
    logic               r_rsp_valid;
    logic [1:0]         r_rsp_status;
    logic [SIZE_W-1:0]  r_rsp_avail;
    logic [UW-1:0]      r_rsp_count;
    logic               r_policy;

    logic               w_valid_k;
    logic               w_cand;
    logic               w_better;
    logic               w_hit;
    logic [SIZE_W+1:0]  w_msum;
    logic [SIZE_W-1:0]  w_msat;
    logic [SIZE_W:0]    w_tsum;
    t_seg               w_new;
    t_seg               w_edit;

    function automatic t_seg pick_src(t_src s, t_seg c, t_seg a1, t_seg a2, t_seg p);
        t_seg r;
        case (s)
            SRC_CUR:  r = c;
            SRC_N1:   r = a1;
            SRC_N2:   r = a2;
            SRC_PREV: r = p;
            default:  r = c;
        endcase
        return r;
    endfunction

    assign w_valid_k = r_k < CW'(r_used);
    assign w_cand    = w_valid_k && i_head.is_free && (i_head.size >= r_size);
    assign w_better  = !r_found || ((r_policy != POL_BEST) ? (i_head.size > r_pick_size)
                                                          : (i_head.size < r_pick_size));
    assign w_hit     = w_valid_k && !r_found && !i_head.is_free && (i_head.owner == r_owner);

    assign w_msum = {2'b00, r_pick_size} + {2'b00, (r_lf ? r_lsize : {SIZE_W{1'b0}})}
                  + {2'b00, (r_rf ? r_rsize : {SIZE_W{1'b0}})};
    assign w_msat = (w_msum[SIZE_W+1:SIZE_W] != 2'b00) ? SIZE_MAX : w_msum[SIZE_W-1:0];
    assign w_tsum = {1'b0, r_free_total} + {1'b0, r_pick_size};

    assign w_new = '{owner: r_owner, size: r_size, is_free: 1'b0};

    always_comb begin
        if (r_ovr_en && (r_k == r_ovr_pos)) begin
            w_edit = r_ovr;
        end else if (r_ins_en && (r_k == r_ins_pos)) begin
            w_edit = w_new;
        end else if (r_k < r_brk) begin
            w_edit = pick_src(r_lo, i_head, i_n1, i_n2, r_prev);
        end else begin
            w_edit = pick_src(r_hi, i_head, i_n1, i_n2, r_prev);
        end
    end

    assign o_shift = (r_state == S_SCAN) || (r_state == S_EDIT);
    assign o_tail  = (r_state == S_EDIT) ? w_edit : i_head;

    assign i_req.ready            = (r_state == S_IDLE);
    assign o_rsp.valid            = r_rsp_valid;
    assign o_rsp.status           = r_rsp_status;
    assign o_rsp.available_memory = r_rsp_avail;
    assign o_rsp.segment_count    = r_rsp_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_free_total <= TOTAL_RST;
            r_used       <= '0;
            r_policy     <= POLICY_RST;
            r_rsp_valid  <= 1'b0;
        end else begin
            if (r_rsp_valid && o_rsp.ready && (r_state != S_RESP)) begin
                r_rsp_valid <= 1'b0;
            end
            if (i_cfg.load) begin
                r_free_total <= i_cfg.total;
                r_used       <= '0;
            end
            r_policy <= i_cfg.policy;
            r_prev   <= i_head;

            case (r_state)
                S_IDLE: begin
                    r_k          <= '0;
                    r_found      <= 1'b0;
                    r_first_free <= 1'b0;
                    r_lf         <= 1'b0;
                    r_rf         <= 1'b0;
                    r_new_total  <= r_free_total;
                    r_new_used   <= r_used;
                    if (i_req.valid) begin
                        r_op    <= i_req.req_type;
                        r_owner <= i_req.owner_id;
                        r_size  <= i_req.request_size;
                        if ((i_req.req_type == REQ_ALLOC) && ((i_req.request_size == '0) ||
                                (i_req.request_size > r_free_total))) begin
                            r_status <= ST_NO_MEM;
                            r_state  <= S_RESP;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_op == REQ_ALLOC) begin
                        if (r_k == '0) begin
                            r_first_free <= (r_used != '0) && i_head.is_free;
                        end
                        if (w_cand && w_better) begin
                            r_found     <= 1'b1;
                            r_pick      <= r_k;
                            r_pick_size <= i_head.size;
                        end
                    end else if (w_hit) begin
                        r_found     <= 1'b1;
                        r_pick      <= r_k;
                        r_pick_size <= i_head.size;
                        r_lf        <= (r_k != '0) && r_prev.is_free;
                        r_lsize     <= r_prev.size;
                        r_rf        <= ((r_k + 1'b1) < CW'(r_used)) && i_n1.is_free;
                        r_rsize     <= i_n1.size;
                    end
                    r_k <= r_k + 1'b1;
                    if (r_k == K_LAST) begin
                        r_state <= S_PLAN;
                    end
                end
                S_PLAN: begin
                    r_k      <= '0;
                    r_status <= ST_OK;
                    r_state  <= S_EDIT;
                    r_ovr_en <= 1'b0;
                    r_ins_en <= 1'b0;
                    r_brk    <= K_ALL;
                    r_lo     <= SRC_CUR;
                    r_hi     <= SRC_CUR;
                    if (r_op == REQ_ALLOC) begin
                        r_new_total <= r_free_total - r_size;
                        if (!r_found) begin
                            if (r_used == U_MAX) begin
                                r_status <= ST_FULL;
                                r_state  <= S_RESP;
                            end
                            r_ins_en   <= 1'b1;
                            r_ins_pos  <= '0;
                            r_brk      <= CW'(1);
                            r_hi       <= SRC_PREV;
                            r_new_used <= r_used + 1'b1;
                        end else if (r_pick_size == r_size) begin
                            r_ovr_en <= 1'b1;
                            r_ovr    <= '{owner: r_owner, size: r_size, is_free: 1'b0};
                            if (r_first_free && (r_pick != '0)) begin
                                r_ovr_pos  <= r_pick - 1'b1;
                                r_lo       <= SRC_N1;
                                r_new_used <= r_used - 1'b1;
                            end else begin
                                r_ovr_pos <= r_pick;
                            end
                        end else begin
                            if (r_used == U_MAX) begin
                                r_status <= ST_FULL;
                                r_state  <= S_RESP;
                            end
                            r_ovr <= '{owner: r_owner, size: r_pick_size - r_size,
                                       is_free: 1'b1};
                            r_ins_en <= 1'b1;
                            if (r_pick == '0) begin
                                r_ins_pos <= '0;
                                r_brk     <= '0;
                            end else if (r_first_free) begin
                                r_ovr_en  <= 1'b1;
                                r_ovr_pos <= r_pick - 1'b1;
                                r_ins_pos <= r_pick;
                                r_lo      <= SRC_N1;
                                r_brk     <= r_pick + 1'b1;
                            end else begin
                                r_ovr_en   <= 1'b1;
                                r_ovr_pos  <= r_pick;
                                r_ins_pos  <= r_pick + 1'b1;
                                r_brk      <= r_pick + CW'(2);
                                r_hi       <= SRC_PREV;
                                r_new_used <= r_used + 1'b1;
                            end
                        end
                    end else begin
                        if (!r_found) begin
                            r_status <= ST_NO_OWN;
                            r_state  <= S_RESP;
                        end
                        r_new_total <= w_tsum[SIZE_W] ? SIZE_MAX : w_tsum[SIZE_W-1:0];
                        r_new_used  <= r_used - UW'(r_lf) - UW'(r_rf);
                        r_ovr_en    <= 1'b1;
                        r_ovr       <= '{owner: r_owner, size: w_msat, is_free: 1'b1};
                        r_ovr_pos   <= r_lf ? (r_pick - 1'b1) : r_pick;
                        r_hi        <= (r_lf && r_rf) ? SRC_N2 : SRC_N1;
                        if (r_lf) begin
                            r_brk <= r_pick;
                        end else if (r_rf) begin
                            r_brk <= r_pick + 1'b1;
                        end
                    end
                end
                S_EDIT: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == K_LAST) begin
                        r_free_total <= r_new_total;
                        r_used       <= r_new_used;
                        r_state      <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (!r_rsp_valid || o_rsp.ready) begin
                        r_rsp_valid  <= 1'b1;
                        r_rsp_status <= r_status;
                        r_rsp_avail  <= r_free_total;
                        r_rsp_count  <= r_used;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/segment_fit_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// segment_fit_allocator_unit
// Segment table allocator with best-fit / worst-fit policy and APB registers.
// ----------------------------------------------------------------------------
// The segment table sits in a ring of MAX_SEGMENTS cells that rotates one
// place a cycle while the ring is scanned or rewritten. An allocate or free
// item is taken in the idle state, then the ring is scanned in one full
// pass, the edit is planned, a second full pass rewrites the ring, and the
// result is loaded into the response register. The next item can be taken
// once the unit is back in the idle state. An allocate refused for size
// goes straight to the response; a full table or an unknown owner skips the
// rewrite. One item is in work at a time; the response register lets the
// next item in while the last result waits, and an item whose result is
// ready holds until that register is free. Register 0 (address 0) is
// total_memory, register 1 (address 4) is fit_policy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module segment_fit_allocator_unit
    import sfa_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEG_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    sfa_req_if.sink          i_req,
    sfa_rsp_if.source        o_rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [SIZE_W-1:0] r_total_memory;
    logic              r_fit_policy;
    logic              w_wr;
    t_cfg              w_cfg;
    t_seg              w_cell [MAX_SEGMENTS];
    t_seg              w_n2;
    t_seg              w_tail;
    logic              w_shift;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_memory <= TOTAL_RST;
            r_fit_policy   <= POLICY_RST;
        end else if (w_wr) begin
            if (paddr[2] == REG_TOTAL) begin
                r_total_memory <= pwdata[SIZE_W-1:0];
            end else begin
                r_fit_policy <= pwdata[0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_POLICY) ? {31'd0, r_fit_policy}
                                             : {{(32-SIZE_W){1'b0}}, r_total_memory};

    assign w_cfg = '{load:   w_wr && (paddr[2] == REG_TOTAL),
                     total:  pwdata[SIZE_W-1:0],
                     policy: r_fit_policy};

    genvar gi;
    generate
        for (gi = 0; gi < MAX_SEGMENTS; gi++) begin : g_cell
            if (gi == MAX_SEGMENTS - 1) begin : g_tail
                sfa_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (w_shift),
                    .i_d     (w_tail),
                    .o_q     (w_cell[gi])
                );
            end else begin : g_body
                sfa_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (w_shift),
                    .i_d     (w_cell[gi+1]),
                    .o_q     (w_cell[gi])
                );
            end
        end
        if (MAX_SEGMENTS > 2) begin : g_n2
            assign w_n2 = w_cell[2];
        end else begin : g_no_n2
            assign w_n2 = '0;
        end
    endgenerate

    sfa_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_head  (w_cell[0]),
        .i_n1    (w_cell[1]),
        .i_n2    (w_n2),
        .o_shift (w_shift),
        .o_tail  (w_tail)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.segment_count <= MAX_SEGMENTS))
        else $error("segment count beyond table depth");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == ST_FULL)) |-> (o_rsp.segment_count == MAX_SEGMENTS))
        else $error("table full reported with free slots");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("second item taken while one is in work");

endmodule

`default_nettype wire
